/* sv/fbd_pkg.sv */
// shared types, constants and datapath command codes for the baud divider search
package fbd_pkg;

	localparam int ClockW = 27;
	localparam int TargetW = 24;
	localparam int BaudW = 23;
	localparam int DlW = 16;
	localparam int FracW = 4;
	localparam int TrialW = 9;
	localparam int WordW = 32;

	localparam logic [ClockW-1:0] CORE_CLOCK_RESET = 27'd120000000;
	localparam logic [TargetW-1:0] FAST_BAUD_LIMIT = 24'd1000000;
	localparam logic [WordW-1:0] FINE_ERR_SCALE = 32'd1536;
	localparam logic [WordW-1:0] COARSE_ERR_SCALE = 32'd200;
	localparam logic [FracW-1:0] MUL_LAST = 4'd15;
	localparam logic [FracW-1:0] DADD_LAST = 4'd14;

	localparam int OpW = 4;
	localparam logic [OpW-1:0] OP_NONE  = 4'd0;
	localparam logic [OpW-1:0] OP_LOAD  = 4'd1;
	localparam logic [OpW-1:0] OP_PREP  = 4'd2;
	localparam logic [OpW-1:0] OP_DIV1  = 4'd3;
	localparam logic [OpW-1:0] OP_DL    = 4'd4;
	localparam logic [OpW-1:0] OP_FIX   = 4'd5;
	localparam logic [OpW-1:0] OP_DIV2  = 4'd6;
	localparam logic [OpW-1:0] OP_DX    = 4'd7;
	localparam logic [OpW-1:0] OP_DIV3  = 4'd8;
	localparam logic [OpW-1:0] OP_BAUD  = 4'd9;
	localparam logic [OpW-1:0] OP_KEEP  = 4'd10;
	localparam logic [OpW-1:0] OP_NEXT  = 4'd11;
	localparam logic [OpW-1:0] OP_NEWPD = 4'd12;
	localparam logic [OpW-1:0] OP_EMIT  = 4'd13;

	typedef struct packed {
		logic [OpW-1:0] op;
	} fbd_cmd_t;

	typedef struct packed {
		logic target_zero;
		logic den_zero;
		logic div_busy;
		logic dl_big;
		logic improve;
		logic fine_exit;
		logic coarse_exit;
		logic last_combo;
		logic pd_zero;
	} fbd_stat_t;

endpackage

/* sv/fbd_div.sv */
// radix-2 restoring 32 by 32 unsigned divider, one quotient bit per cycle
module fbd_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [fbd_pkg::WordW-1:0] dividend,
	input  logic [fbd_pkg::WordW-1:0] divisor,
	output logic busy,
	output logic [fbd_pkg::WordW-1:0] quotient
);
	localparam int CntW = $clog2(fbd_pkg::WordW + 1);

	logic [CntW-1:0] cnt_q;
	logic [fbd_pkg::WordW-1:0] rem_q;
	logic [fbd_pkg::WordW-1:0] quo_q;
	logic [fbd_pkg::WordW-1:0] den_q;
	logic [fbd_pkg::WordW:0] trial;
	logic take;

	assign trial = {rem_q, quo_q[fbd_pkg::WordW-1]};
	assign take = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(fbd_pkg::WordW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= take ? fbd_pkg::WordW'(trial - {1'b0, den_q}) : trial[fbd_pkg::WordW-1:0];
			quo_q <= {quo_q[fbd_pkg::WordW-2:0], take};
		end
	end

	assign busy = cnt_q != '0;
	assign quotient = quo_q;
endmodule

/* sv/fbd_datapath.sv */
// search datapath: clock register, trial arithmetic, best candidate and result words
module fbd_datapath (
	input  logic clk,
	input  logic arst_n,
	input  fbd_pkg::fbd_cmd_t cmd,
	output fbd_pkg::fbd_stat_t stat,
	input  logic cfg_we,
	input  logic [fbd_pkg::ClockW-1:0] cfg_data,
	input  logic [fbd_pkg::TargetW-1:0] req_baud,
	output logic [fbd_pkg::BaudW-1:0] actual_baud,
	output logic [1:0] prescale_shift,
	output logic [fbd_pkg::DlW-1:0] divisor_latch,
	output logic [fbd_pkg::FracW-1:0] frac_multiplier,
	output logic [fbd_pkg::FracW-1:0] frac_divide_add,
	output logic [fbd_pkg::TrialW-1:0] trials_made
);
	localparam int W = fbd_pkg::WordW;
	localparam int FW = fbd_pkg::FracW;

	logic [fbd_pkg::ClockW-1:0] clock_q;
	logic [fbd_pkg::TargetW-1:0] target_q;
	logic [1:0] pd_q;
	logic [FW-1:0] mul_q, dadd_q;
	logic [fbd_pkg::TrialW-1:0] trials_q;
	logic [W-1:0] num_q, den_q, dl_q, base_q, prod_q, dx_q, baud_q, dist_q;
	logic [W-1:0] best_baud_q, best_dist_q;
	logic [fbd_pkg::DlW-1:0] dl_fix_q, best_dl_q;
	logic [1:0] best_pd_q;
	logic [FW-1:0] best_mul_q, best_dadd_q;

	logic [fbd_pkg::ClockW-1:0] pclk;
	logic [W-1:0] target32, quot, div_a, div_b, base_n, fine_p, coarse_p;
	logic [fbd_pkg::DlW-1:0] dl_fix;
	logic [FW:0] dsum;
	logic div_start, div_busy;

	assign pclk = clock_q >> pd_q;
	assign target32 = W'(target_q);
	assign dsum = {1'b0, dadd_q} + {1'b0, mul_q};

	always_comb begin
		dl_fix = dl_q[fbd_pkg::DlW-1:0];
		if (dl_fix == '0) begin
			dl_fix = 16'd1;
		end
		if (dadd_q != '0 && dl_fix < 16'd2) begin
			dl_fix = 16'd2;
		end
		base_n = {4'd0, dl_fix, 12'd0};
	end

	always_comb begin
		div_start = 1'b0;
		div_a = num_q;
		div_b = den_q;
		case (cmd.op)
			fbd_pkg::OP_DIV1: begin
				div_start = 1'b1;
			end
			fbd_pkg::OP_DIV2: begin
				div_start = 1'b1;
				div_a = prod_q;
				div_b = W'(mul_q);
			end
			fbd_pkg::OP_DIV3: begin
				div_start = 1'b1;
				div_a = {pclk, 5'd0};
				div_b = dx_q;
			end
			default: begin
			end
		endcase
	end

	fbd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_a),
		.divisor(div_b),
		.busy(div_busy),
		.quotient(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= fbd_pkg::CORE_CLOCK_RESET;
		end else if (cfg_we) begin
			clock_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			fbd_pkg::OP_LOAD: begin
				target_q <= req_baud;
				pd_q <= (req_baud < fbd_pkg::FAST_BAUD_LIMIT) ? 2'd3 : 2'd1;
				mul_q <= 4'd1;
				dadd_q <= '0;
				trials_q <= '0;
				best_baud_q <= '0;
				best_dist_q <= W'(req_baud);
				best_pd_q <= '0;
				best_dl_q <= '0;
				best_mul_q <= '0;
				best_dadd_q <= '0;
			end
			fbd_pkg::OP_PREP: begin
				trials_q <= trials_q + 1'b1;
				num_q <= W'({mul_q, 1'b0} * W'(pclk));
				den_q <= W'(target32 * W'(dsum)) << 4;
			end
			fbd_pkg::OP_DL: begin
				dl_q <= (quot + 1'b1) >> 1;
			end
			fbd_pkg::OP_FIX: begin
				dl_fix_q <= dl_fix;
				base_q <= base_n;
				prod_q <= W'(base_n * W'(dadd_q));
			end
			fbd_pkg::OP_DX: begin
				dx_q <= base_q + quot;
			end
			fbd_pkg::OP_BAUD: begin
				baud_q <= quot << 3;
				dist_q <= ((quot << 3) >= target32) ? (quot << 3) - target32
					: target32 - (quot << 3);
			end
			fbd_pkg::OP_KEEP: begin
				best_baud_q <= baud_q;
				best_dist_q <= dist_q;
				best_pd_q <= pd_q;
				best_dl_q <= dl_fix_q;
				best_mul_q <= mul_q;
				best_dadd_q <= dadd_q;
			end
			fbd_pkg::OP_NEXT: begin
				if (FW'(dadd_q + 1'b1) < mul_q) begin
					dadd_q <= dadd_q + 1'b1;
				end else begin
					dadd_q <= '0;
					mul_q <= mul_q + 1'b1;
				end
			end
			fbd_pkg::OP_NEWPD: begin
				pd_q <= pd_q - 1'b1;
				mul_q <= 4'd1;
				dadd_q <= '0;
			end
			fbd_pkg::OP_EMIT: begin
				actual_baud <= best_baud_q[fbd_pkg::BaudW-1:0];
				prescale_shift <= best_pd_q;
				divisor_latch <= best_dl_q;
				frac_multiplier <= best_mul_q;
				frac_divide_add <= best_dadd_q;
				trials_made <= trials_q;
			end
			default: begin
			end
		endcase
	end

	assign fine_p = W'(dist_q * fbd_pkg::FINE_ERR_SCALE);
	assign coarse_p = W'(best_dist_q * fbd_pkg::COARSE_ERR_SCALE);

	always_comb begin
		stat.target_zero = target_q == '0;
		stat.den_zero = den_q == '0;
		stat.div_busy = div_busy;
		stat.dl_big = dl_q[W-1:fbd_pkg::DlW] != '0;
		stat.improve = dist_q < best_dist_q;
		stat.fine_exit = (baud_q == target32) || (fine_p < target32);
		stat.coarse_exit = coarse_p < target32;
		stat.last_combo = (mul_q == fbd_pkg::MUL_LAST) && (dadd_q == fbd_pkg::DADD_LAST);
		stat.pd_zero = pd_q == '0;
	end
endmodule

/* sv/fbd_ctrl.sv */
// search sequencer: walks prescale, multiplier and divide-add and drives the datapath
module fbd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  fbd_pkg::fbd_stat_t stat,
	output fbd_pkg::fbd_cmd_t cmd
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_ZCHK = 5'd1;
	localparam logic [4:0] S_PREP = 5'd2;
	localparam logic [4:0] S_DZ   = 5'd3;
	localparam logic [4:0] S_W1   = 5'd4;
	localparam logic [4:0] S_DL   = 5'd5;
	localparam logic [4:0] S_FIX  = 5'd6;
	localparam logic [4:0] S_D2   = 5'd7;
	localparam logic [4:0] S_W2   = 5'd8;
	localparam logic [4:0] S_DX   = 5'd9;
	localparam logic [4:0] S_W3   = 5'd10;
	localparam logic [4:0] S_BAUD = 5'd11;
	localparam logic [4:0] S_CMP  = 5'd12;
	localparam logic [4:0] S_ADV  = 5'd13;
	localparam logic [4:0] S_PEND = 5'd14;
	localparam logic [4:0] S_FIN  = 5'd15;
	localparam logic [4:0] S_D3   = 5'd16;

	logic [4:0] state_q, state_n;
	logic out_valid_q;
	logic emit;

	assign in_ready = state_q == S_IDLE;
	assign emit = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_n = state_q;
		cmd.op = fbd_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = fbd_pkg::OP_LOAD;
					state_n = S_ZCHK;
				end
			end
			S_ZCHK: state_n = stat.target_zero ? S_FIN : S_PREP;
			S_PREP: begin
				cmd.op = fbd_pkg::OP_PREP;
				state_n = S_DZ;
			end
			S_DZ: begin
				if (stat.den_zero) begin
					state_n = S_ADV;
				end else begin
					cmd.op = fbd_pkg::OP_DIV1;
					state_n = S_W1;
				end
			end
			S_W1: if (!stat.div_busy) state_n = S_DL;
			S_DL: begin
				cmd.op = fbd_pkg::OP_DL;
				state_n = S_FIX;
			end
			S_FIX: begin
				if (stat.dl_big) begin
					state_n = S_ADV;
				end else begin
					cmd.op = fbd_pkg::OP_FIX;
					state_n = S_D2;
				end
			end
			S_D2: begin
				cmd.op = fbd_pkg::OP_DIV2;
				state_n = S_W2;
			end
			S_W2: if (!stat.div_busy) state_n = S_DX;
			S_DX: begin
				cmd.op = fbd_pkg::OP_DX;
				state_n = S_D3;
			end
			S_D3: begin
				cmd.op = fbd_pkg::OP_DIV3;
				state_n = S_W3;
			end
			S_W3: if (!stat.div_busy) state_n = S_BAUD;
			S_BAUD: begin
				cmd.op = fbd_pkg::OP_BAUD;
				state_n = S_CMP;
			end
			S_CMP: begin
				state_n = S_ADV;
				if (stat.improve) begin
					cmd.op = fbd_pkg::OP_KEEP;
					if (stat.fine_exit) begin
						state_n = S_FIN;
					end
				end
			end
			S_ADV: begin
				if (stat.last_combo) begin
					state_n = S_PEND;
				end else begin
					cmd.op = fbd_pkg::OP_NEXT;
					state_n = S_PREP;
				end
			end
			S_PEND: begin
				if (stat.coarse_exit || stat.pd_zero) begin
					state_n = S_FIN;
				end else begin
					cmd.op = fbd_pkg::OP_NEWPD;
					state_n = S_PREP;
				end
			end
			S_FIN: begin
				if (emit) begin
					cmd.op = fbd_pkg::OP_EMIT;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

/* sv/fractional_baud_divider_search.sv */
// top level of the fractional baud divider search
// Usage: write core_clock_hz on the cfg channel (cfg_valid/cfg_ready, always ready) while idle;
// it resets to 120000000. Offer a req_baud word on in_valid/in_ready; one result word
// (actual_baud, prescale_shift, divisor_latch, frac_multiplier, frac_divide_add,
// trials_made) comes back on out_valid/out_ready.
// Search steps: a trial that reaches the baud computation makes three passes of the one shared
// serial divider; a trial with a zero denominator or an oversize divisor is skipped without
// the baud computation. A full search makes up to 480 trials; a zero target gives an
// all-zero result without any trial.
// One target is searched at a time; in_ready is high only between searches.
// The result sits in an output register: a new target can be taken while it waits.
// If the receiver stalls, a finished search holds until the output register frees up.
// Reset clears the sequencer and output valid and restores the clock register.
module fractional_baud_divider_search (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [fbd_pkg::ClockW-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [fbd_pkg::TargetW-1:0] req_baud,
	output logic out_valid,
	input  logic out_ready,
	output logic [fbd_pkg::BaudW-1:0] actual_baud,
	output logic [1:0] prescale_shift,
	output logic [fbd_pkg::DlW-1:0] divisor_latch,
	output logic [fbd_pkg::FracW-1:0] frac_multiplier,
	output logic [fbd_pkg::FracW-1:0] frac_divide_add,
	output logic [fbd_pkg::TrialW-1:0] trials_made
);
	fbd_pkg::fbd_cmd_t cmd;
	fbd_pkg::fbd_stat_t stat;

	assign cfg_ready = 1'b1;

	fbd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat(stat),
		.cmd(cmd)
	);

	fbd_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cfg_we(cfg_valid),
		.cfg_data(cfg_data),
		.req_baud(req_baud),
		.actual_baud(actual_baud),
		.prescale_shift(prescale_shift),
		.divisor_latch(divisor_latch),
		.frac_multiplier(frac_multiplier),
		.frac_divide_add(frac_divide_add),
		.trials_made(trials_made)
	);
endmodule

/* sim/tb_top.sv */
// self-checking testbench for the fractional baud divider search: directed, random and stall tests
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic [fbd_pkg::BaudW-1:0] baud;
		logic [1:0] shift;
		logic [fbd_pkg::DlW-1:0] dl;
		logic [fbd_pkg::FracW-1:0] mul;
		logic [fbd_pkg::FracW-1:0] dadd;
		logic [fbd_pkg::TrialW-1:0] trials;
	} baud_setting_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [fbd_pkg::ClockW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [fbd_pkg::TargetW-1:0] req_baud;
	logic out_valid;
	logic out_ready;
	logic [fbd_pkg::BaudW-1:0] actual_baud;
	logic [1:0] prescale_shift;
	logic [fbd_pkg::DlW-1:0] divisor_latch;
	logic [fbd_pkg::FracW-1:0] frac_multiplier;
	logic [fbd_pkg::FracW-1:0] frac_divide_add;
	logic [fbd_pkg::TrialW-1:0] trials_made;

	baud_setting_t expected_settings[$];
	logic [fbd_pkg::ClockW-1:0] model_clock_hz;
	int src_idle_pct;
	int snk_stall_pct;
	int hold_cycles;
	int mismatches;
	int targets_sent;
	int results_seen;
	int clocks_used;

	fractional_baud_divider_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_baud(req_baud),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.actual_baud(actual_baud),
		.prescale_shift(prescale_shift),
		.divisor_latch(divisor_latch),
		.frac_multiplier(frac_multiplier),
		.frac_divide_add(frac_divide_add),
		.trials_made(trials_made)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [31:0] baud_dist(input logic [31:0] a, input logic [31:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic baud_setting_t search_divider(input logic [31:0] clock_hz,
			input logic [31:0] target);
		baud_setting_t best;
		logic [31:0] best_baud, pclk, num, den, dl, base, dx, b, m, d, trials;
		int pd, mi, di;
		bit done;
		best = '0;
		best_baud = 0;
		trials = 0;
		done = 0;
		if (target != 0) begin
			for (pd = (target < 32'd1000000) ? 3 : 1; pd >= 0 && !done; pd--) begin
				pclk = clock_hz >> pd;
				for (mi = 1; mi < 16 && !done; mi++) begin
					for (di = 0; di < mi && !done; di++) begin
						m = mi;
						d = di;
						trials = trials + 1;
						num = 32'd2 * m * pclk;
						den = 32'd16 * target * (d + m);
						if (den == 0)
							continue;
						dl = (num / den + 32'd1) / 32'd2;
						if (dl > 32'd65535)
							continue;
						if (dl == 0)
							dl = 1;
						if (d > 0 && dl < 2)
							dl = 2;
						base = dl * 32'd4096;
						dx = base + (base * d) / m;
						b = ((pclk * 32'd32) / dx) * 32'd8;
						if (baud_dist(b, target) < baud_dist(best_baud, target)) begin
							best_baud = b;
							best.shift = pd[1:0];
							best.dl = dl[fbd_pkg::DlW-1:0];
							best.mul = m[fbd_pkg::FracW-1:0];
							best.dadd = d[fbd_pkg::FracW-1:0];
							if (b == target)
								done = 1;
							else if ((baud_dist(b, target) * fbd_pkg::FINE_ERR_SCALE) / target
									== 0)
								done = 1;
						end
					end
				end
				if (!done && (baud_dist(best_baud, target) * fbd_pkg::COARSE_ERR_SCALE)
						/ target == 0)
					done = 1;
			end
		end
		best.baud = best_baud[fbd_pkg::BaudW-1:0];
		best.trials = trials[fbd_pkg::TrialW-1:0];
		return best;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// long receiver hold-off count
	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles--;
	end

	// result checker and receiver
	always @(posedge clk or negedge arst_n) begin
		baud_setting_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_settings.size() == 0) begin
					report_mismatch("unexpected word", actual_baud, 0);
				end else begin
					want = expected_settings.pop_front();
					if (actual_baud !== want.baud)
						report_mismatch("actual_baud", actual_baud, want.baud);
					if (prescale_shift !== want.shift)
						report_mismatch("prescale_shift", prescale_shift, want.shift);
					if (divisor_latch !== want.dl)
						report_mismatch("divisor_latch", divisor_latch, want.dl);
					if (frac_multiplier !== want.mul)
						report_mismatch("frac_multiplier", frac_multiplier, want.mul);
					if (frac_divide_add !== want.dadd)
						report_mismatch("frac_divide_add", frac_divide_add, want.dadd);
					if (trials_made !== want.trials)
						report_mismatch("trials_made", trials_made, want.trials);
				end
			end
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	task automatic send_target(input logic [fbd_pkg::TargetW-1:0] t);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_baud <= t;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		expected_settings.push_back(search_divider(model_clock_hz, t));
		targets_sent++;
	endtask

	task automatic write_clock(input logic [fbd_pkg::ClockW-1:0] hz);
		in_valid <= 1'b0;
		wait (expected_settings.size() == 0);
		repeat (200) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= hz;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		cfg_valid <= 1'b0;
		model_clock_hz = hz;
		clocks_used++;
	endtask

	function automatic logic [fbd_pkg::TargetW-1:0] random_target();
		int pick;
		int common_bauds[10] = '{300, 1200, 9600, 19200, 38400, 57600, 115200, 230400,
			460800, 921600};
		pick = $urandom_range(99);
		if (pick < 50)
			return fbd_pkg::TargetW'(common_bauds[$urandom_range(9)]);
		else if (pick < 80)
			return fbd_pkg::TargetW'($urandom_range(9000000, 1));
		else if (pick < 95)
			return fbd_pkg::TargetW'($urandom_range(5000, 1));
		else
			return fbd_pkg::TargetW'($urandom);
	endfunction

	task automatic test_reset_clock();
		logic [fbd_pkg::TargetW-1:0] dir[14] = '{24'd0, 24'd1, 24'd9600, 24'd115200,
			24'd999999, 24'd1000000, 24'd9000000, 24'hFFFFFF, 24'd300, 24'd3000000,
			24'h800000, 24'h555555, 24'hAAAAAA, 24'd250000};
		foreach (dir[i])
			send_target(dir[i]);
	endtask

	task automatic test_clock_extremes();
		write_clock(27'd1000000);
		send_target(24'd9600);
		send_target(24'd1000000);
		send_target(24'd0);
		write_clock(27'h7FFFFFF);
		send_target(24'd115200);
		send_target(24'd9000000);
		send_target(24'd1);
	endtask

	task automatic test_random(input int n, input int idle, input int stall,
			input logic [fbd_pkg::ClockW-1:0] hz);
		src_idle_pct = idle;
		snk_stall_pct = stall;
		write_clock(hz);
		repeat (n)
			send_target(random_target());
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		write_clock(27'd120000000);
		hold_cycles = 4000;
		repeat (6)
			send_target($urandom_range(1) ? 24'd0 : 24'd115200);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_baud = '0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_cycles = 0;
		mismatches = 0;
		targets_sent = 0;
		results_seen = 0;
		clocks_used = 0;
		model_clock_hz = fbd_pkg::CORE_CLOCK_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_clock();
		test_clock_extremes();
		test_random(19, 0, 0, 27'd48000000);
		test_random(19, 61, 0, 27'd120000000);
		test_random(19, 0, 61, 27'd14745600);
		test_random(19, 31, 31, fbd_pkg::ClockW'($urandom_range(27'h7FFFFFF, 27'd1000000)));
		test_backpressure();
		in_valid <= 1'b0;
		wait (expected_settings.size() == 0);
		repeat (50) @(posedge clk);
		$display("covered %0d target words and %0d result words over %0d clock settings",
			targets_sent, results_seen, clocks_used);
		$display("idle and stall phases plus one long receiver hold-off, %0d mismatches",
			mismatches);
		if (mismatches == 0 && expected_settings.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#(64'd20000000 * 12);
		$display("FAIL");
		$finish;
	end

endmodule

/* fractional_baud_divider_search.f */
sv/fbd_pkg.sv
sv/fbd_div.sv
sv/fbd_datapath.sv
sv/fbd_ctrl.sv
sv/fractional_baud_divider_search.sv
sim/tb_top.sv
